// ----- sv/cdds_pkg.sv -----
// ----------------------------------------------------------------------------
// cdds_pkg: shared types and constants for the chirp DMA descriptor sequencer
// Register map, item and descriptor layouts, controller state encoding and
// the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package cdds_pkg;

    // field widths
    localparam int CW_W      = 16;
    localparam int DMA_W     = 10;
    localparam int NDMA_W    = 6;
    localparam int IDEAL_W   = 22;
    localparam int SF_W      = 4;
    localparam int SYM_W     = 12;
    localparam int CARRY_W   = 22;
    localparam int LEN_W     = 12;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    // start word arithmetic
    localparam int PROD_W    = SYM_W + CW_W;          // symbol * chirp length
    localparam int QPROD_W   = CW_W + 2;              // quarter * chirp length
    localparam int SUM_W     = PROD_W + 1;
    localparam int WORD_W    = CW_W + 2;              // start + k * dma_words
    localparam int DVD_W     = 32;                    // dividend, padded
    localparam int DIV_RADIX_BITS = 4;                // quotient bits per cycle
    localparam int DIV_STEPS = DVD_W / DIV_RADIX_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_CHIRP_WORDS      = 3'd0;
    localparam logic [2:0] REG_DMA_WORDS        = 3'd1;
    localparam logic [2:0] REG_DMAS_PER_QUARTER = 3'd2;
    localparam logic [2:0] REG_IDEAL_BITS       = 3'd3;
    localparam logic [2:0] REG_SPREAD_FACTOR    = 3'd4;

    // register reset values
    localparam logic [CW_W-1:0]    RST_CHIRP_WORDS      = 16'd1024;
    localparam logic [DMA_W-1:0]   RST_DMA_WORDS        = 10'd32;
    localparam logic [NDMA_W-1:0]  RST_DMAS_PER_QUARTER = 6'd8;
    localparam logic [IDEAL_W-1:0] RST_IDEAL_BITS       = 22'd8192;
    localparam logic [SF_W-1:0]    RST_SPREAD_FACTOR    = 4'd7;

    typedef struct packed {
        logic [CW_W-1:0]    chirp_words;
        logic [DMA_W-1:0]   dma_words;
        logic [NDMA_W-1:0]  dmas_per_quarter;
        logic [IDEAL_W-1:0] ideal_quarter_bits;
        logic [SF_W-1:0]    spread_factor;
    } cfg_t;

    typedef struct packed {
        logic             down_chirp;
        logic [SYM_W-1:0] symbol_value;
        logic [1:0]       quarter_index;
        logic             start_of_message;
        logic             end_of_message;
    } quarter_t;

    typedef struct packed {
        logic             use_down_table;
        logic [CW_W-1:0]  word_offset;
        logic [LEN_W-1:0] length_bytes;
        logic             idle;
        logic             last;
    } desc_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROD,
        S_SUM,
        S_DIV,
        S_EMIT,
        S_TAIL
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture item, reset descriptor count
        logic calc_prod;   // symbol * chirp length
        logic calc_sum;    // scale, add quarter offset, arm divider
        logic div_step;    // one radix-16 remainder step
        logic emit_data;   // load next data descriptor
        logic emit_idle;   // load the idle descriptor
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_div;    // up item with nonzero chirp length
        logic div_done;    // final remainder step this cycle
        logic zero_desc;   // no data descriptors configured
        logic last_desc;   // current descriptor is the final data one
        logic out_free;    // output register can take a descriptor
        logic eom;         // item asked for the idle descriptor
    } status_t;

endpackage

// ----- sv/chirp_dma_descriptor_sequencer.sv -----
// ----------------------------------------------------------------------------
// chirp_dma_descriptor_sequencer: quarter-chirp to DMA descriptor sequencer
// Turns each quarter-chirp item into a run of DMA descriptors for the chirp
// pattern tables, trimming lengths by a running bit carry.
// ----------------------------------------------------------------------------
// Usage:
//   quarter_item enters on quarter_valid/quarter_stall; descriptors leave on
//   desc_valid/desc_stall, one item per handshake, in order. Settings sit in
//   an APB-style register file (always ready). Settings must be written
//   only between items; the block itself does not enforce this. One item is
//   in flight at a time. After acceptance the product is registered, then
//   the scaled sum; an up item with a nonzero chirp length then passes
//   through the radix-16 remainder unit (32-bit dividend, 4 bits per cycle).
//   Descriptors then leave one per cycle while desc_stall is low, plus one
//   for the idle descriptor on an end-of-message item.
//   The descriptor output register lets the next item be accepted while the
//   final descriptor still waits. A stall on desc_stall holds the current
//   descriptor and pauses emission. Reset loads the default settings, clears
//   the bit carry and empties the output register.
// ----------------------------------------------------------------------------
module chirp_dma_descriptor_sequencer
    import cdds_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              quarter_valid,
    output logic              quarter_stall,
    input  quarter_t          quarter_item,
    output logic              desc_valid,
    input  logic              desc_stall,
    output desc_t             desc_item,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    cdds_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cdds_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .quarter_valid (quarter_valid),
        .quarter_stall (quarter_stall),
        .status        (status),
        .cmd           (cmd)
    );

    cdds_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .quarter_item (quarter_item),
        .cmd          (cmd),
        .status       (status),
        .desc_stall   (desc_stall),
        .desc_valid   (desc_valid),
        .desc_item    (desc_item)
    );

endmodule

// ----- sv/cdds_regs.sv -----
// ----------------------------------------------------------------------------
// cdds_regs: configuration register file
// APB-style slave holding the five sequencer settings; always ready.
// ----------------------------------------------------------------------------
module cdds_regs
    import cdds_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel & penable & pwrite;
    assign cfg     = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.chirp_words        <= RST_CHIRP_WORDS;
            cfg_reg.dma_words          <= RST_DMA_WORDS;
            cfg_reg.dmas_per_quarter   <= RST_DMAS_PER_QUARTER;
            cfg_reg.ideal_quarter_bits <= RST_IDEAL_BITS;
            cfg_reg.spread_factor      <= RST_SPREAD_FACTOR;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_CHIRP_WORDS:      cfg_reg.chirp_words        <= pwdata[CW_W-1:0];
                REG_DMA_WORDS:        cfg_reg.dma_words          <= pwdata[DMA_W-1:0];
                REG_DMAS_PER_QUARTER: cfg_reg.dmas_per_quarter   <= pwdata[NDMA_W-1:0];
                REG_IDEAL_BITS:       cfg_reg.ideal_quarter_bits <= pwdata[IDEAL_W-1:0];
                REG_SPREAD_FACTOR:    cfg_reg.spread_factor      <= pwdata[SF_W-1:0];
                default:              ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_idx)
            REG_CHIRP_WORDS:      prdata = DATA_W'(cfg_reg.chirp_words);
            REG_DMA_WORDS:        prdata = DATA_W'(cfg_reg.dma_words);
            REG_DMAS_PER_QUARTER: prdata = DATA_W'(cfg_reg.dmas_per_quarter);
            REG_IDEAL_BITS:       prdata = DATA_W'(cfg_reg.ideal_quarter_bits);
            REG_SPREAD_FACTOR:    prdata = DATA_W'(cfg_reg.spread_factor);
            default:              prdata = '0;
        endcase
    end

endmodule

// ----- sv/cdds_datapath.sv -----
// ----------------------------------------------------------------------------
// cdds_datapath: start word, remainder unit, descriptor generation
// Holds the item, the bit carry, the radix-16 remainder unit and the
// descriptor output register.
// ----------------------------------------------------------------------------
module cdds_datapath
    import cdds_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  quarter_t quarter_item,
    input  cmd_t     cmd,
    output status_t  status,
    input  logic     desc_stall,
    output logic     desc_valid,
    output desc_t    desc_item
);

    quarter_t               item_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [DVD_W-1:0]       dvd_reg;
    logic [CW_W-1:0]        rem_reg;
    logic [DIV_CNT_W-1:0]   div_cnt_reg;
    logic [WORD_W-1:0]      word_reg;
    logic [NDMA_W-1:0]      k_reg;
    logic [CARRY_W-1:0]     carry_reg;
    logic [CARRY_W-1:0]     carry_next;
    logic                   desc_valid_reg;
    desc_t                  desc_reg;

    logic [QPROD_W-1:0]     qprod;
    logic [CW_W-1:0]        qterm;
    logic [PROD_W-1:0]      scaled;
    logic [SUM_W-1:0]       sum;
    logic [CW_W-1:0]        rem_next;
    logic [WORD_W-1:0]      wrapped;
    logic [WORD_W-1:0]      word_out;
    logic [CARRY_W:0]       after;
    logic signed [CARRY_W+1:0] over;
    logic [LEN_W-1:0]       len_full;
    logic [LEN_W+7:0]       trim;
    logic [LEN_W-1:0]       len;
    logic                   need_div;

    // start word pieces
    assign qprod    = QPROD_W'(item_reg.quarter_index) * QPROD_W'(cfg.chirp_words);
    assign qterm    = qprod[QPROD_W-1:2];
    assign scaled   = prod_reg >> cfg.spread_factor;
    assign sum      = SUM_W'(scaled) + SUM_W'(qterm);
    assign need_div = !item_reg.down_chirp && (cfg.chirp_words != '0);

    // four restoring remainder steps per cycle
    always_comb
    begin
        logic [CW_W:0] trial;
        logic [CW_W-1:0] r;
        r = rem_reg;
        for (int i = 0; i < DIV_RADIX_BITS; i++)
        begin
            trial = {r, dvd_reg[DVD_W-1-i]};
            if (trial >= {1'b0, cfg.chirp_words})
            begin
                trial = trial - {1'b0, cfg.chirp_words};
            end
            r = trial[CW_W-1:0];
        end
        rem_next = r;
    end

    // word offset: one wrap, mirrored down offsets get one added
    assign wrapped  = (word_reg >= WORD_W'(cfg.chirp_words))
                    ? word_reg - WORD_W'(cfg.chirp_words) : word_reg;
    assign word_out = wrapped + WORD_W'(item_reg.down_chirp);

    // length trim by the running bit carry
    assign after    = {1'b0, carry_reg} + (CARRY_W+1)'({cfg.dma_words, 5'b0});
    assign over     = $signed({1'b0, after}) - $signed((CARRY_W+2)'(cfg.ideal_quarter_bits));
    assign len_full = {cfg.dma_words, 2'b00};
    assign trim     = {over[CARRY_W:5], 2'b00};

    always_comb
    begin
        if (!over[CARRY_W+1])
        begin
            len        = (trim > (LEN_W+8)'(len_full)) ? '0 : len_full - trim[LEN_W-1:0];
            carry_next = CARRY_W'(over[4:0]);
        end
        else
        begin
            len        = len_full;
            carry_next = after[CARRY_W-1:0];
        end
    end

    // item, product and remainder registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= quarter_item;
        end
        if (cmd.calc_prod)
        begin
            prod_reg <= PROD_W'(item_reg.symbol_value) * PROD_W'(cfg.chirp_words);
        end
        if (cmd.calc_sum)
        begin
            dvd_reg <= DVD_W'(sum);
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= dvd_reg << DIV_RADIX_BITS;
            rem_reg <= rem_next;
        end
    end

    // descriptor walk and divider count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
            word_reg    <= '0;
            k_reg       <= '0;
            carry_reg   <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                k_reg <= '0;
                if (quarter_item.start_of_message)
                begin
                    carry_reg <= '0;
                end
            end
            if (cmd.calc_sum)
            begin
                div_cnt_reg <= '0;
                word_reg    <= item_reg.down_chirp ? WORD_W'(qterm) : '0;
            end
            if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
                if (status.div_done)
                begin
                    word_reg <= WORD_W'(rem_next);
                end
            end
            if (cmd.emit_data)
            begin
                k_reg     <= k_reg + 1'b1;
                word_reg  <= word_reg + WORD_W'(cfg.dma_words);
                carry_reg <= carry_next;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desc_valid_reg <= 1'b0;
        end
        else if (cmd.emit_data || cmd.emit_idle)
        begin
            desc_valid_reg <= 1'b1;
        end
        else if (!desc_stall)
        begin
            desc_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_data)
        begin
            desc_reg.use_down_table <= item_reg.down_chirp;
            desc_reg.word_offset    <= word_out[CW_W-1:0];
            desc_reg.length_bytes   <= len;
            desc_reg.idle           <= 1'b0;
            desc_reg.last           <= status.last_desc && !item_reg.end_of_message;
        end
        else if (cmd.emit_idle)
        begin
            desc_reg.use_down_table <= 1'b0;
            desc_reg.word_offset    <= '0;
            desc_reg.length_bytes   <= len_full;
            desc_reg.idle           <= 1'b1;
            desc_reg.last           <= 1'b1;
        end
    end

    assign desc_valid = desc_valid_reg;
    assign desc_item  = desc_reg;

    // status to controller
    assign status.need_div  = need_div;
    assign status.div_done  = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign status.zero_desc = (cfg.dmas_per_quarter == '0);
    assign status.last_desc = ({1'b0, k_reg} + 1'b1) == {1'b0, cfg.dmas_per_quarter};
    assign status.out_free  = !desc_valid_reg || !desc_stall;
    assign status.eom       = item_reg.end_of_message;

    // the idle descriptor always closes its item and points at word zero
    a_idle_shape: assert property (@(posedge clk) disable iff (!rst_n)
        desc_valid_reg && desc_reg.idle |-> desc_reg.last && desc_reg.word_offset == '0)
        else $error("idle descriptor malformed");

    // a loaded descriptor is presented in the next cycle
    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_data || cmd.emit_idle |=> desc_valid_reg)
        else $error("emitted descriptor not presented");

    // a stalled descriptor stays put
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        desc_valid_reg && desc_stall |=> desc_valid_reg && $stable(desc_reg))
        else $error("stalled descriptor changed");

endmodule

// ----- sv/cdds_ctrl.sv -----
// ----------------------------------------------------------------------------
// cdds_ctrl: sequencing state machine
// Steps one item through product, sum, remainder and descriptor emission.
// ----------------------------------------------------------------------------
module cdds_ctrl
    import cdds_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    quarter_valid,
    output logic    quarter_stall,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    state_t after_start;

    // where to go once the start word is known
    always_comb
    begin
        if (!status.zero_desc)
        begin
            after_start = S_EMIT;
        end
        else if (status.eom)
        begin
            after_start = S_TAIL;
        end
        else
        begin
            after_start = S_IDLE;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (quarter_valid)
                begin
                    state_next = S_PROD;
                end
            end
            S_PROD: state_next = S_SUM;
            S_SUM:  state_next = status.need_div ? S_DIV : after_start;
            S_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = after_start;
                end
            end
            S_EMIT:
            begin
                if (status.out_free && status.last_desc)
                begin
                    state_next = status.eom ? S_TAIL : S_IDLE;
                end
            end
            S_TAIL:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd           = '0;
        quarter_stall = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                quarter_stall = 1'b0;
                cmd.load      = quarter_valid;
            end
            S_PROD: cmd.calc_prod = 1'b1;
            S_SUM:  cmd.calc_sum  = 1'b1;
            S_DIV:  cmd.div_step  = 1'b1;
            S_EMIT: cmd.emit_data = status.out_free;
            S_TAIL: cmd.emit_idle = status.out_free;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // at most one datapath command per cycle
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.calc_prod, cmd.calc_sum, cmd.div_step,
                  cmd.emit_data, cmd.emit_idle}))
        else $error("overlapping datapath commands");

    // the remainder unit runs its full step count
    a_div_holds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV && !status.div_done |=> state_reg == S_DIV)
        else $error("remainder unit left early");

    // the idle descriptor only follows an end-of-message item
    a_idle_eom: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_idle |-> status.eom)
        else $error("idle descriptor without end of message");

endmodule

// ----- verif/chirp_dma_descriptor_sequencer_tb.sv -----
// ----------------------------------------------------------------------------
// chirp_dma_descriptor_sequencer_tb: self-checking bench for the sequencer
// Drives quarter-chirp items through a bursty sender, stalls the descriptor
// side on a changing pattern, and checks every descriptor against an
// in-bench model of the start word, wrap, bit carry and idle tail. Settings
// are reprogrammed over the register port between phases and read back.
// ----------------------------------------------------------------------------
module chirp_dma_descriptor_sequencer_tb;
    import cdds_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;   // cycles with no item moving
    localparam int SETTLE_CYCLES  = 100;    // outlasts one item with no stall
    localparam int DIR_ROWS       = 16;
    localparam int RANDOM_PHASES  = 5;
    localparam int ITEMS_PER_PHASE = 19;
    localparam int IDEAL_MAX      = 2097152;
    localparam int MAX_PRINTS     = 50;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    // one row of the directed table; gold is the first descriptor, if typed
    typedef struct {
        logic     load_cfg;
        cfg_t     cfg;
        quarter_t item;
        logic     has_gold;
        desc_t    gold;
    } step_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              quarter_valid = 1'b0;
    logic              quarter_stall;
    quarter_t          quarter_item = '0;
    logic              desc_valid;
    logic              desc_stall = 1'b0;
    desc_t             desc_item;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // model state and bookkeeping
    cfg_t               cfg_model;
    logic [CARRY_W-1:0] carry_bits;
    desc_t              pending_desc[$];
    int                 mismatches = 0;
    int                 items_sent = 0;
    int                 descs_checked = 0;
    int                 cfg_settings = 0;
    int                 idle_cycles = 0;
    int                 burst_left = 0;
    stall_mode_t        stall_mode = STALL_NONE;
    int                 stall_run = 0;
    int                 stall_tick = 0;
    step_row_t          dir_rows[DIR_ROWS];

    chirp_dma_descriptor_sequencer DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .quarter_valid (quarter_valid),
        .quarter_stall (quarter_stall),
        .quarter_item  (quarter_item),
        .desc_valid    (desc_valid),
        .desc_stall    (desc_stall),
        .desc_item     (desc_item),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatches < MAX_PRINTS)
            $display("MISMATCH @%0t: %s got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // descriptors caused by one quarter item, pushed in emission order
    function automatic void compute_descriptors(input quarter_t q);
        longint cw;
        longint dw;
        longint start;
        longint word;
        longint carry_sum;
        longint excess;
        longint len;
        longint n;
        desc_t  d;
        cw = cfg_model.chirp_words;
        dw = cfg_model.dma_words;
        n  = cfg_model.dmas_per_quarter;
        if (q.start_of_message)
            carry_bits = '0;
        if (q.down_chirp)
            start = longint'(q.quarter_index) * cw / 4;
        else if (cw == 0)
            start = 0;
        else
            start = (((longint'(q.symbol_value) * cw) >> cfg_model.spread_factor)
                     + longint'(q.quarter_index) * cw / 4) % cw;
        for (longint k = 0; k < n; k++)
        begin
            // single wrap, down offsets mirrored by one
            word = k * dw + start;
            if (word >= cw)
                word -= cw;
            if (q.down_chirp)
                word += 1;
            // trim by the running bit carry
            carry_sum = longint'(carry_bits) + dw * 32;
            excess = carry_sum - longint'(cfg_model.ideal_quarter_bits);
            if (excess >= 0)
            begin
                len = dw * 4 - 4 * (excess / 32);
                carry_bits = CARRY_W'(excess % 32);
            end
            else
            begin
                len = dw * 4;
                carry_bits = CARRY_W'(carry_sum);
            end
            if (len < 0)
                len = 0;
            d.use_down_table = q.down_chirp;
            d.word_offset    = CW_W'(word);
            d.length_bytes   = LEN_W'(len);
            d.idle           = 1'b0;
            d.last           = (k == n - 1) && !q.end_of_message;
            pending_desc.push_back(d);
        end
        // idle tail points at the zero buffer
        if (q.end_of_message)
        begin
            d.use_down_table = 1'b0;
            d.word_offset    = '0;
            d.length_bytes   = LEN_W'(dw * 4);
            d.idle           = 1'b1;
            d.last           = 1'b1;
            pending_desc.push_back(d);
        end
    endfunction

    function automatic logic [DATA_W-1:0] reg_value(input cfg_t c, input logic [2:0] r);
        case (r)
            REG_CHIRP_WORDS:      return DATA_W'(c.chirp_words);
            REG_DMA_WORDS:        return DATA_W'(c.dma_words);
            REG_DMAS_PER_QUARTER: return DATA_W'(c.dmas_per_quarter);
            REG_IDEAL_BITS:       return DATA_W'(c.ideal_quarter_bits);
            default:              return DATA_W'(c.spread_factor);
        endcase
    endfunction

    function automatic quarter_t make_quarter(input bit down, input int sym, input int qi,
                                              input bit som, input bit eom);
        quarter_t q;
        q.down_chirp       = down;
        q.symbol_value     = SYM_W'(sym);
        q.quarter_index    = 2'(qi);
        q.start_of_message = som;
        q.end_of_message   = eom;
        return q;
    endfunction

    function automatic step_row_t table_row(input bit load, input int cw, input int dw,
                                            input int n, input int ideal, input int sf,
                                            input bit down, input int sym, input int qi,
                                            input bit som, input bit eom, input bit gold,
                                            input bit g_down, input int g_word,
                                            input int g_len, input bit g_idle,
                                            input bit g_last);
        step_row_t row;
        row.load_cfg                = load;
        row.cfg.chirp_words         = CW_W'(cw);
        row.cfg.dma_words           = DMA_W'(dw);
        row.cfg.dmas_per_quarter    = NDMA_W'(n);
        row.cfg.ideal_quarter_bits  = IDEAL_W'(ideal);
        row.cfg.spread_factor       = SF_W'(sf);
        row.item                    = make_quarter(down, sym, qi, som, eom);
        row.has_gold                = gold;
        row.gold.use_down_table     = g_down;
        row.gold.word_offset        = CW_W'(g_word);
        row.gold.length_bytes       = LEN_W'(g_len);
        row.gold.idle               = g_idle;
        row.gold.last               = g_last;
        return row;
    endfunction

    function automatic cfg_t random_cfg();
        cfg_t   c;
        longint nominal;
        longint ideal;
        case ($urandom_range(0, 7))
            0:       c.chirp_words = 16'd65535;
            1:       c.chirp_words = 16'd4;
            2:       c.chirp_words = CW_W'($urandom_range(4, 65535));
            default: c.chirp_words = CW_W'($urandom_range(4, 4096));
        endcase
        case ($urandom_range(0, 7))
            0:       c.dma_words = 10'd1023;
            1:       c.dma_words = 10'd1;
            default: c.dma_words = DMA_W'($urandom_range(1, 64));
        endcase
        case ($urandom_range(0, 9))
            0:       c.dmas_per_quarter = 6'd63;
            1:       c.dmas_per_quarter = 6'd0;
            default: c.dmas_per_quarter = NDMA_W'($urandom_range(1, 10));
        endcase
        // half the time near the nominal quarter size so the carry trims lengths
        nominal = longint'(c.dma_words) * 32 * longint'(c.dmas_per_quarter);
        case ($urandom_range(0, 3))
            0:       ideal = $urandom_range(1, IDEAL_MAX);
            1:       ideal = $urandom_range(1, 64);
            default: ideal = nominal - 64 + $urandom_range(0, 128);
        endcase
        if (ideal < 1)
            ideal = 1;
        if (ideal > IDEAL_MAX)
            ideal = IDEAL_MAX;
        c.ideal_quarter_bits = IDEAL_W'(ideal);
        c.spread_factor = SF_W'($urandom_range(6, 12));
        return c;
    endfunction

    function automatic int random_symbol();
        case ($urandom_range(0, 7))
            0:       return 4095;
            1:       return 0;
            default: return $urandom_range(0, 4095);
        endcase
    endfunction

    // register port: setup then access; caller lowers psel after the last one
    task automatic write_reg(input logic [2:0] r, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
    endtask

    task automatic read_reg(input logic [2:0] r, output logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {r, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        value = prdata;
    endtask

    task automatic check_regs();
        logic [DATA_W-1:0] got;
        logic [DATA_W-1:0] mask;
        for (int r = REG_CHIRP_WORDS; r <= REG_SPREAD_FACTOR; r++)
        begin
            read_reg(3'(r), got);
            case (3'(r))
                REG_CHIRP_WORDS:      mask = (1 << CW_W) - 1;
                REG_DMA_WORDS:        mask = (1 << DMA_W) - 1;
                REG_DMAS_PER_QUARTER: mask = (1 << NDMA_W) - 1;
                REG_IDEAL_BITS:       mask = (1 << IDEAL_W) - 1;
                default:              mask = (1 << SF_W) - 1;
            endcase
            if ((got & mask) != reg_value(cfg_model, 3'(r)))
                report_mismatch($sformatf("register %0d readback", r),
                                got & mask, reg_value(cfg_model, 3'(r)));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_config(input cfg_t c);
        for (int r = REG_CHIRP_WORDS; r <= REG_SPREAD_FACTOR; r++)
            write_reg(3'(r), reg_value(c, 3'(r)));
        cfg_model = c;
        cfg_settings++;
        check_regs();
    endtask

    // hold valid until the item is taken; valid is lowered by the pacing
    task automatic send_quarter(input quarter_t q);
        quarter_valid <= 1'b1;
        quarter_item  <= q;
        do
            @(posedge clk);
        while (quarter_stall);
        items_sent++;
    endtask

    // bursts of items with random gaps, now and then a long unbroken run
    task automatic pace_sender();
        if (burst_left > 0)
            burst_left--;
        else
        begin
            quarter_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(0, 7);
        end
    endtask

    // idle the block: all descriptors out, then room for an item with no result
    task automatic drain_and_settle();
        quarter_valid <= 1'b0;
        while (pending_desc.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // receiver stall pattern
    always @(posedge clk)
    begin
        if (stall_run == 0)
        begin
            stall_mode <= stall_mode_t'($urandom_range(0, 3));
            stall_run  <= $urandom_range(8, 60);
        end
        else
            stall_run <= stall_run - 1;
        stall_tick <= (stall_tick == 2) ? 0 : stall_tick + 1;
        case (stall_mode)
            STALL_NONE:  desc_stall <= 1'b0;
            STALL_LIGHT: desc_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: desc_stall <= ($urandom_range(0, 9) < 7);
            default:     desc_stall <= (stall_tick == 2);
        endcase
    end

    // descriptor checker and watchdog
    always @(posedge clk)
    begin
        desc_t want;
        if (rst_n)
        begin
            if (desc_valid && !desc_stall)
            begin
                descs_checked++;
                if (pending_desc.size() == 0)
                    report_mismatch("descriptor with none pending, word_offset",
                                    desc_item.word_offset, 0);
                else
                begin
                    want = pending_desc.pop_front();
                    if (desc_item.use_down_table !== want.use_down_table)
                        report_mismatch("use_down_table", desc_item.use_down_table,
                                        want.use_down_table);
                    if (desc_item.word_offset !== want.word_offset)
                        report_mismatch("word_offset", desc_item.word_offset,
                                        want.word_offset);
                    if (desc_item.length_bytes !== want.length_bytes)
                        report_mismatch("length_bytes", desc_item.length_bytes,
                                        want.length_bytes);
                    if (desc_item.idle !== want.idle)
                        report_mismatch("idle", desc_item.idle, want.idle);
                    if (desc_item.last !== want.last)
                        report_mismatch("last", desc_item.last, want.last);
                end
            end
            if ((quarter_valid && !quarter_stall) || (desc_valid && !desc_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no item moved for %0d cycles", idle_cycles);
                $display("chirp_dma_descriptor_sequencer regression: fail");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        quarter_t q;
        int       sent_here;
        int       msg_len;
        int       first;

        cfg_model.chirp_words        = RST_CHIRP_WORDS;
        cfg_model.dma_words          = RST_DMA_WORDS;
        cfg_model.dmas_per_quarter   = RST_DMAS_PER_QUARTER;
        cfg_model.ideal_quarter_bits = RST_IDEAL_BITS;
        cfg_model.spread_factor      = RST_SPREAD_FACTOR;
        carry_bits = '0;

        // load cw dw n ideal sf | down sym q som eom | gold down word len idle last
        dir_rows = '{
            // reset settings: one full quarter leaves the carry at zero
            table_row(0, 0, 0, 0, 0, 0,         0,    0, 0, 1, 0,  1, 0, 0, 128, 0, 0),
            table_row(0, 0, 0, 0, 0, 0,         1,    0, 0, 0, 0,  1, 1, 1, 128, 0, 0),
            table_row(0, 0, 0, 0, 0, 0,         0, 4095, 3, 0, 1,  0, 0, 0, 0, 0, 0),
            table_row(0, 0, 0, 0, 0, 0,         1, 4095, 2, 0, 1,  0, 0, 0, 0, 0, 0),
            // widest table and transfers, one-bit quarter: large wrap
            table_row(1, 65535, 1023, 63, 1, 12, 0, 4095, 3, 1, 0, 0, 0, 0, 0, 0, 0),
            table_row(0, 0, 0, 0, 0, 0,         1,    0, 3, 0, 1,  0, 0, 0, 0, 0, 0),
            // huge ideal quarter builds up a large carry
            table_row(1, 4, 1023, 63, IDEAL_MAX, 6, 0, 0, 1, 1, 0, 0, 0, 0, 0, 0, 0),
            // carried bits exceed the new transfer: length saturates at zero
            table_row(1, 4, 1, 2, 1, 6,         1,    0, 0, 0, 1,  1, 1, 1, 0, 0, 0),
            table_row(0, 0, 0, 0, 0, 0,         0,   63, 2, 1, 0,  0, 0, 0, 0, 0, 0),
            // zero chirp length: start word 0, no wrap
            table_row(1, 0, 5, 3, 100, 8,       0, 4095, 3, 1, 0,  1, 0, 0, 16, 0, 0),
            table_row(0, 0, 0, 0, 0, 0,         1,    0, 3, 0, 1,  0, 0, 0, 0, 0, 0),
            // no data descriptors: idle tail only, or nothing at all
            table_row(1, 1024, 32, 0, 8192, 7,  0,    1, 1, 0, 1,  1, 0, 0, 128, 1, 1),
            table_row(0, 0, 0, 0, 0, 0,         1,    0, 0, 0, 0,  0, 0, 0, 0, 0, 0),
            table_row(0, 0, 0, 0, 0, 0,         0,    2, 1, 0, 0,  0, 0, 0, 0, 0, 0),
            table_row(1, 1000, 7, 5, 500, 10,   0, 2048, 1, 0, 1,  0, 0, 0, 0, 0, 0),
            table_row(0, 0, 0, 0, 0, 0,         1,    1, 1, 1, 0,  0, 0, 0, 0, 0, 0)
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_regs();

        // directed table
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_rows[i].load_cfg)
            begin
                drain_and_settle();
                apply_config(dir_rows[i].cfg);
            end
            send_quarter(dir_rows[i].item);
            first = pending_desc.size();
            compute_descriptors(dir_rows[i].item);
            if (dir_rows[i].has_gold)
                pending_desc[first] = dir_rows[i].gold;
            pace_sender();
        end

        // random phases: mostly well-formed messages, some stray items
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            drain_and_settle();
            apply_config(random_cfg());
            sent_here = 0;
            while (sent_here < ITEMS_PER_PHASE)
            begin
                if ($urandom_range(0, 4) == 0)
                    msg_len = 1;
                else
                    msg_len = $urandom_range(2, 8);
                for (int j = 0; j < msg_len; j++)
                begin
                    if (msg_len == 1)
                        q = make_quarter($urandom_range(0, 1), random_symbol(),
                                         $urandom_range(0, 3), $urandom_range(0, 1),
                                         $urandom_range(0, 1));
                    else
                        q = make_quarter($urandom_range(0, 3) == 0, random_symbol(),
                                         j % 4, j == 0, j == msg_len - 1);
                    send_quarter(q);
                    compute_descriptors(q);
                    pace_sender();
                    sent_here++;
                end
            end
        end

        drain_and_settle();
        if (pending_desc.size() != 0)
            report_mismatch("descriptors never seen", pending_desc.size(), 0);

        $display("run covered %0d quarter items and %0d descriptors", items_sent,
                 descs_checked);
        $display("over %0d register settings, with %0d mismatches", cfg_settings,
                 mismatches);
        if (mismatches == 0)
            $display("chirp_dma_descriptor_sequencer regression: pass");
        else
            $display("chirp_dma_descriptor_sequencer regression: fail");
        $finish;
    end

endmodule

// ----- chirp_dma_descriptor_sequencer.f -----
sv/cdds_pkg.sv
sv/cdds_regs.sv
sv/cdds_datapath.sv
sv/cdds_ctrl.sv
sv/chirp_dma_descriptor_sequencer.sv
verif/chirp_dma_descriptor_sequencer_tb.sv
